[hdl/gregorian_date_arithmetic_assert.svh]
// Assertion macros shared by the date arithmetic modules.
// Users must have clk and rst in scope; no other dependencies.
`ifndef GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH

// same-cycle implication
`define GDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gda_pkg.sv]
// Shared types, constants and calendar functions for the date arithmetic block.
// No dependencies.
package gda_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 15;
  localparam int BTW_W  = 22;
  localparam int REM_W  = 18;
  localparam int CEN_W  = 8;
  localparam int YR_W   = 7;

  localparam logic [2:0] OP_ADD_DAYS     = 3'd0;
  localparam logic [2:0] OP_ADD_WEEKS    = 3'd1;
  localparam logic [2:0] OP_ADD_MONTHS   = 3'd2;
  localparam logic [2:0] OP_ADD_YEARS    = 3'd3;
  localparam logic [2:0] OP_DAYS_BETWEEN = 3'd4;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

  // floor(x / 100) = (x * 5243) >> 19 for x < 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [REM_W-1:0] MONTHS_PER_YEAR = 18'd12;
  localparam logic [REM_W-1:0] MONTHS_SKIP     = 18'd96;
  localparam logic [YEAR_W-1:0] YEARS_SKIP     = 14'd8;

  typedef struct packed {
    logic capture;
    logic split_q;
    logic split_r;
    logic side;
    logic set_bad;
    logic load_rem;
    logic add_years;
    logic step_day;
    logic step_mon;
    logic ser_a;
    logic ser_b;
    logic diff;
    logic out_load;
  } gda_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       start_ok;
    logic       end_ok;
    logic       day_fin;
    logic       mon_fin;
  } gda_stat_t;

  // year given as 100*q + r
  function automatic logic is_leap(input logic [CEN_W-1:0] q, input logic [YR_W-1:0] r);
    is_leap = (r == 7'd0) ? (q[1:0] == 2'd0) : (r[1:0] == 2'd0);
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m, input logic leap);
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days_in = 5'd30;
      4'd2:                                       days_in = leap ? 5'd29 : 5'd28;
      default:                                    days_in = 5'd0;
    endcase
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m);
    unique case (m)
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

endpackage

[hdl/gda_dp.sv]
// Datapath: request registers, year split by 100, day/month stepping, serial days.
// Depends on gda_pkg and gregorian_date_arithmetic_assert.svh.
`include "gregorian_date_arithmetic_assert.svh"

module gda_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         s_tdata,
  input  logic [3:0]          s_tuser,
  input  gda_pkg::gda_cmd_t   cmd,
  output gda_pkg::gda_stat_t  stat,
  output logic [47:0]         m_tdata,
  output logic [1:0]          m_tuser
);

  logic [2:0]                        op;
  logic [gda_pkg::DAY_W-1:0]         d, ed;
  logic [gda_pkg::MON_W-1:0]         m, em;
  logic [gda_pkg::YEAR_W-1:0]        y, ey;
  logic [gda_pkg::CNT_W-1:0]         cnt;
  logic                              inc;
  logic [gda_pkg::CEN_W-1:0]         yq, eq, qtmp;
  logic [gda_pkg::YR_W-1:0]          yr, er;
  logic [gda_pkg::REM_W-1:0]         rem;
  logic [gda_pkg::BTW_W-1:0]         sacc, s1, between;
  logic [1:0]                        status;

  logic [gda_pkg::DAY_W-1:0]         o_day;
  logic [gda_pkg::MON_W-1:0]         o_month;
  logic [gda_pkg::YEAR_W-1:0]        o_year;
  logic [gda_pkg::BTW_W-1:0]         o_between;
  logic [1:0]                        o_status;

  // split by 100
  logic [gda_pkg::YEAR_W-1:0]        x;
  logic [26:0]                       prod;
  logic [gda_pkg::YEAR_W-1:0]        q_x100;
  logic [gda_pkg::YR_W-1:0]          r_split;

  assign x       = cmd.side ? ey : y;
  assign prod    = 27'(x) * 27'(gda_pkg::DIV100_MUL);
  assign q_x100  = 14'(qtmp) * 14'd100;
  assign r_split = 7'(x - q_x100);

  // validity
  logic                       leap_y, leap_e, leap_n, leap_s;
  logic [gda_pkg::DAY_W-1:0]  dim_y, dim_e;

  assign leap_y = gda_pkg::is_leap(yq, yr);
  assign leap_e = gda_pkg::is_leap(eq, er);
  assign dim_y  = gda_pkg::days_in(m, leap_y);
  assign dim_e  = gda_pkg::days_in(em, leap_e);

  assign stat.op       = op;
  assign stat.start_ok = (m != 4'd0) && (m <= 4'd12) && (y != 14'd0)
                         && (y <= gda_pkg::MAX_YEAR) && (d != 5'd0) && (d <= dim_y);
  assign stat.end_ok   = (em != 4'd0) && (em <= 4'd12) && (ey != 14'd0)
                         && (ey <= gda_pkg::MAX_YEAR) && (ed != 5'd0) && (ed <= dim_e);

  // next year and year + 8 in split form
  logic [gda_pkg::CEN_W-1:0]  nq, nq8;
  logic [gda_pkg::YR_W-1:0]   nr, nr8, r8;
  logic                       wrap8;

  assign nr     = (yr == 7'd99) ? 7'd0 : yr + 7'd1;
  assign nq     = (yr == 7'd99) ? yq + 8'd1 : yq;
  assign leap_n = gda_pkg::is_leap(nq, nr);
  assign r8     = yr + 7'(gda_pkg::YEARS_SKIP);
  assign wrap8  = r8 >= 7'd100;
  assign nr8    = wrap8 ? r8 - 7'd100 : r8;
  assign nq8    = wrap8 ? yq + 8'd1 : yq;

  logic [gda_pkg::YEAR_W-1:0] y_inc, y8;
  logic                       y_ovf1, ovf8;

  assign y_inc  = y + 14'd1;
  assign y8     = y + gda_pkg::YEARS_SKIP;
  assign y_ovf1 = (y == gda_pkg::MAX_YEAR);
  assign ovf8   = (y8 > gda_pkg::MAX_YEAR);

  // day stepping
  logic [8:0]                 ylen;
  logic [gda_pkg::DAY_W-1:0]  dl;
  logic                       year_skip, fits;

  assign ylen      = ((m <= 4'd2) ? leap_y : leap_n) ? 9'd366 : 9'd365;
  assign dl        = dim_y - d;
  assign year_skip = (d == 5'd1) && (rem >= 18'(ylen));
  assign fits      = rem <= 18'(dl);
  assign stat.day_fin = year_skip ? y_ovf1 : (fits || ((m == 4'd12) && y_ovf1));

  // month stepping
  logic                       short_day, skip8, skip1;
  logic [gda_pkg::MON_W-1:0]  m_inc;
  logic [gda_pkg::DAY_W-1:0]  dim_mi;

  assign short_day = d <= 5'd28;
  assign skip8     = short_day && (rem >= gda_pkg::MONTHS_SKIP);
  assign skip1     = short_day && (rem >= gda_pkg::MONTHS_PER_YEAR);
  assign m_inc     = m + 4'd1;
  assign dim_mi    = gda_pkg::days_in(m_inc, leap_y);
  assign stat.mon_fin = (rem == 18'd0)
                        || (skip8 ? ovf8 : (skip1 ? y_ovf1 : ((m == 4'd12) && y_ovf1)));

  // serial day number
  logic [gda_pkg::DAY_W-1:0]  sd;
  logic [gda_pkg::MON_W-1:0]  sm;
  logic [gda_pkg::YEAR_W-1:0] sy, p;
  logic [gda_pkg::CEN_W-1:0]  sq, pq;
  logic [gda_pkg::YR_W-1:0]   sr;
  logic [gda_pkg::BTW_W-1:0]  s_val;

  assign sd     = cmd.side ? ed : d;
  assign sm     = cmd.side ? em : m;
  assign sy     = cmd.side ? ey : y;
  assign sq     = cmd.side ? eq : yq;
  assign sr     = cmd.side ? er : yr;
  assign leap_s = cmd.side ? leap_e : leap_y;
  assign p      = sy - 14'd1;
  assign pq     = (sr == 7'd0) ? sq - 8'd1 : sq;
  assign s_val  = sacc - 22'(pq) + 22'(pq >> 2) + 22'(gda_pkg::cum_days(sm))
                  + 22'((sm > 4'd2) && leap_s) + 22'(sd);

  logic [15:0] ysum;
  assign ysum = 16'(y) + 16'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= s_tuser[2:0];
      inc     <= s_tuser[3];
      d       <= s_tdata[4:0];
      m       <= s_tdata[8:5];
      y       <= s_tdata[22:9];
      cnt     <= s_tdata[37:23];
      ed      <= s_tdata[42:38];
      em      <= s_tdata[46:43];
      ey      <= s_tdata[60:47];
      status  <= gda_pkg::STAT_OK;
      between <= '0;
    end
    if (cmd.split_q) begin
      qtmp <= prod[gda_pkg::DIV100_SHIFT +: gda_pkg::CEN_W];
    end
    if (cmd.split_r) begin
      if (cmd.side) begin
        eq <= qtmp;
        er <= r_split;
      end else begin
        yq <= qtmp;
        yr <= r_split;
      end
    end
    if (cmd.set_bad) begin
      status <= gda_pkg::STAT_BAD;
    end
    if (cmd.load_rem) begin
      rem <= (op == gda_pkg::OP_ADD_WEEKS) ? (18'(cnt) << 3) - 18'(cnt) : 18'(cnt);
    end
    if (cmd.add_years) begin
      if (ysum > 16'(gda_pkg::MAX_YEAR)) begin
        y      <= gda_pkg::MAX_YEAR;
        status <= gda_pkg::STAT_OVF;
      end else begin
        y <= ysum[gda_pkg::YEAR_W-1:0];
      end
    end
    if (cmd.step_day) begin
      if (stat.day_fin && !fits) begin
        d      <= 5'd31;
        m      <= 4'd12;
        y      <= gda_pkg::MAX_YEAR;
        status <= gda_pkg::STAT_OVF;
      end else if (year_skip) begin
        y   <= y_inc;
        yq  <= nq;
        yr  <= nr;
        rem <= rem - 18'(ylen);
      end else if (fits) begin
        d <= d + rem[gda_pkg::DAY_W-1:0];
      end else begin
        rem <= rem - 18'(dl) - 18'd1;
        d   <= 5'd1;
        if (m == 4'd12) begin
          m  <= 4'd1;
          y  <= y_inc;
          yq <= nq;
          yr <= nr;
        end else begin
          m <= m_inc;
        end
      end
    end
    if (cmd.step_mon && (rem != 18'd0)) begin
      if (stat.mon_fin) begin
        d      <= 5'd31;
        m      <= 4'd12;
        y      <= gda_pkg::MAX_YEAR;
        status <= gda_pkg::STAT_OVF;
      end else if (skip8) begin
        y   <= y8;
        yq  <= nq8;
        yr  <= nr8;
        rem <= rem - gda_pkg::MONTHS_SKIP;
      end else if (skip1) begin
        y   <= y_inc;
        yq  <= nq;
        yr  <= nr;
        rem <= rem - gda_pkg::MONTHS_PER_YEAR;
      end else begin
        rem <= rem - 18'd1;
        if (m == 4'd12) begin
          m  <= 4'd1;
          y  <= y_inc;
          yq <= nq;
          yr <= nr;
        end else begin
          m <= m_inc;
          if (d > dim_mi) begin
            d <= dim_mi;
          end
        end
      end
    end
    if (cmd.ser_a) begin
      sacc <= 22'(p) * 22'd365 + 22'(p >> 2);
    end
    if (cmd.ser_b) begin
      sacc <= s_val;
      if (!cmd.side) begin
        s1 <= s_val;
      end
    end
    if (cmd.diff) begin
      between <= ((s1 < sacc) ? sacc - s1 : 22'd0) + 22'(inc);
    end
    if (cmd.out_load) begin
      o_day     <= d;
      o_month   <= m;
      o_year    <= y;
      o_between <= between;
      o_status  <= status;
    end
  end

  assign m_tdata = {3'b000, o_between, o_year, o_month, o_day};
  assign m_tuser = o_status;

  `GDA_ASSERT_NEXT(a_rem_falls, (cmd.step_day || cmd.step_mon), (rem <= $past(rem)), "step count grew")
  `GDA_ASSERT_NEXT(a_status_code, cmd.out_load, (o_status == gda_pkg::STAT_OK || o_status == gda_pkg::STAT_OVF || o_status == gda_pkg::STAT_BAD), "bad status code")

endmodule

[hdl/gda_ctrl.sv]
// Controller: sequences split, check, stepping and serial phases; owns output valid.
// Depends on gda_pkg and gregorian_date_arithmetic_assert.svh.
`include "gregorian_date_arithmetic_assert.svh"

module gda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  gda_pkg::gda_stat_t  stat,
  output gda_pkg::gda_cmd_t   cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SPLIT_Q  = 10'b0000000010,
    S_SPLIT_R  = 10'b0000000100,
    S_CHECK    = 10'b0000001000,
    S_STEP_DAY = 10'b0000010000,
    S_STEP_MON = 10'b0000100000,
    S_SER_A    = 10'b0001000000,
    S_SER_B    = 10'b0010000000,
    S_DIFF     = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   side, side_next;
  logic   out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd        = '0;
    cmd.side   = side;
    state_next = state;
    side_next  = side;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          side_next   = 1'b0;
          state_next  = S_SPLIT_Q;
        end
      end
      S_SPLIT_Q: begin
        cmd.split_q = 1'b1;
        state_next  = S_SPLIT_R;
      end
      S_SPLIT_R: begin
        cmd.split_r = 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        if (side) begin
          if (!stat.end_ok) begin
            cmd.set_bad = 1'b1;
            state_next  = S_DONE;
          end else begin
            side_next  = 1'b0;
            state_next = S_SER_A;
          end
        end else begin
          priority if (stat.op > gda_pkg::OP_DAYS_BETWEEN) begin
            state_next = S_DONE;
          end else if (!stat.start_ok) begin
            cmd.set_bad = 1'b1;
            state_next  = S_DONE;
          end else begin
            unique case (stat.op)
              gda_pkg::OP_ADD_DAYS, gda_pkg::OP_ADD_WEEKS: begin
                cmd.load_rem = 1'b1;
                state_next   = S_STEP_DAY;
              end
              gda_pkg::OP_ADD_MONTHS: begin
                cmd.load_rem = 1'b1;
                state_next   = S_STEP_MON;
              end
              gda_pkg::OP_ADD_YEARS: begin
                cmd.add_years = 1'b1;
                state_next    = S_DONE;
              end
              gda_pkg::OP_DAYS_BETWEEN: begin
                side_next  = 1'b1;
                state_next = S_SPLIT_Q;
              end
              default: state_next = S_DONE;
            endcase
          end
        end
      end
      S_STEP_DAY: begin
        cmd.step_day = 1'b1;
        if (stat.day_fin) begin
          state_next = S_DONE;
        end
      end
      S_STEP_MON: begin
        cmd.step_mon = 1'b1;
        if (stat.mon_fin) begin
          state_next = S_DONE;
        end
      end
      S_SER_A: begin
        cmd.ser_a  = 1'b1;
        state_next = S_SER_B;
      end
      S_SER_B: begin
        cmd.ser_b = 1'b1;
        if (side) begin
          state_next = S_DIFF;
        end else begin
          side_next  = 1'b1;
          state_next = S_SER_A;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `GDA_ASSERT_NOW(a_load_free, cmd.out_load, (!out_valid || m_tready), "result overwritten")
  `GDA_ASSERT_NEXT(a_accept_split, (s_tvalid && s_tready), (state == S_SPLIT_Q), "accept lost")

endmodule

[hdl/gregorian_date_arithmetic.sv]
// Gregorian date arithmetic: add days/weeks/months/years or count days between dates.
// Top level; depends on gda_pkg, gda_ctrl and gda_dp.
//
// Usage:
//   One request in on the s_ channel, one result out on the m_ channel.
//   s_tuser carries the operation and the end-inclusion flag; s_tdata the dates
//   and count. m_tdata carries the result date and day count; m_tuser the status.
//   A request is taken only while the sequencer is idle (s_tready high).
// Processing after a request is accepted:
//   add years, bad start date or unused code: year split and date check only;
//   bad end date: also the end-date split and check; days between: both splits,
//   both checks, both serial day numbers and the difference.
//   add days/weeks: then one step per whole year skipped, month step or final
//   day step (one calendar step per cycle).
//   add months: then one step per 8-year jump, year jump or single month, ending
//   once the count runs out. Requests are handled one at a time; the next request
//   is accepted the cycle after the result is loaded.
// Reset clears the sequencer and the output valid; no pending result survives.
// A stalled receiver holds the result in the output register; the next request
// is still accepted and processed, and waits at its end for the register to free.
module gregorian_date_arithmetic (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // day, month, year, count, end_day, end_month, end_year, 0s
  input  logic [3:0]  s_tuser,  // operation, include_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // res_day, res_month, res_year, days_between, 0s
  output logic [1:0]  m_tuser   // status
);

  gda_pkg::gda_cmd_t  cmd;
  gda_pkg::gda_stat_t stat;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gda_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
